// ===== rtl/ake256_pkg.sv =====
// ake256_pkg: constants, sequencer codes and control struct for the 256-bit key expansion.
// Used by the word unit, the sequencer, the core and both test files; depends on nothing.
package ake256_pkg;

  localparam int unsigned Rounds   = 16;
  localparam int unsigned NumKeys  = Rounds / 2;
  localparam int unsigned KeyWords = 8;
  localparam int unsigned PassW    = $clog2(Rounds);
  localparam int unsigned WordIdxW = $clog2(KeyWords);
  localparam int unsigned KeyIdxW  = 5;

  localparam logic [31:0] Golden = 32'h9E3779B9;

  localparam logic [KeyWords-1:0][31:0] XorConst = {
    32'h644c7ad7, 32'h47c6abd9, 32'h2ef6ef14, 32'h98317698,
    32'hcf4c5d88, 32'h25e9e4d5, 32'h7bd0dfca, 32'h38183a08
  };

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MIX  = 4'b0010,
    ST_DIFF = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  typedef struct packed {
    logic                idle;
    logic                load;
    logic                mix;
    logic                step;
    logic                pass_end;
    logic                emit;
    logic                last;
    logic [WordIdxW-1:0] word_idx;
    logic [KeyIdxW-1:0]  key_idx;
  } ctl_t;

endpackage

// ===== rtl/ake256_if.sv =====
// ake256_key_if / ake256_rk_if: valid/ready channels for input keys and round-key words.
// Depends on nothing.
interface ake256_key_if;
  logic        valid;
  logic        ready;
  logic [63:0] key_bytes_0_7;
  logic [63:0] key_bytes_8_15;
  logic [63:0] key_bytes_16_23;
  logic [63:0] key_bytes_24_31;

  modport source (output valid, key_bytes_0_7, key_bytes_8_15, key_bytes_16_23,
                  key_bytes_24_31, input ready);
  modport sink   (input valid, key_bytes_0_7, key_bytes_8_15, key_bytes_16_23,
                  key_bytes_24_31, output ready);
endinterface

interface ake256_rk_if;
  logic        valid;
  logic        ready;
  logic [4:0]  round_number;
  logic [63:0] round_bytes_0_7;
  logic [63:0] round_bytes_8_15;
  logic [63:0] round_bytes_16_23;
  logic [63:0] round_bytes_24_31;
  logic        final_round_key;

  modport source (output valid, round_number, round_bytes_0_7, round_bytes_8_15,
                  round_bytes_16_23, round_bytes_24_31, final_round_key, input ready);
  modport sink   (input valid, round_number, round_bytes_0_7, round_bytes_8_15,
                  round_bytes_16_23, round_bytes_24_31, final_round_key, output ready);
endinterface

// ===== rtl/ake256_word_unit.sv =====
// ake256_word_unit: shared add-rotate-add update of one working word.
// Depends on ake256_pkg.
module ake256_word_unit (
  input  logic [31:0]                        a_i,
  input  logic [31:0]                        b_i,
  input  logic [31:0]                        c_i,
  input  logic [31:0]                        d_i,
  input  logic [31:0]                        rc_i,
  input  logic [ake256_pkg::WordIdxW-1:0]    idx_i,
  output logic [31:0]                        y_o
);

  localparam logic [ake256_pkg::KeyWords-1:0][4:0] RotTable = {
    5'd17, 5'd12, 5'd13, 5'd2, 5'd8, 5'd21, 5'd11, 5'd7
  };

  logic [31:0] sum;
  logic [63:0] dbl;

  assign sum = b_i + c_i;
  assign dbl = {sum, sum} << RotTable[idx_i];
  assign y_o = a_i + dbl[63:32] + d_i + rc_i;

endmodule

// ===== rtl/ake256_ctrl.sv =====
// ake256_ctrl: sequencer for load, byte mix, diffusion passes and emission.
// Depends on ake256_pkg.
module ake256_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             slot_free_i,
  output ake256_pkg::ctl_t ctl_o
);

  ake256_pkg::state_e                  state_q, state_d;
  logic [ake256_pkg::WordIdxW-1:0]     word_q, word_d;
  logic [ake256_pkg::PassW-1:0]        pass_q, pass_d;
  logic [ake256_pkg::KeyIdxW-1:0]      key_q, key_d;
  logic                                word_end, pass_last, key_last;

  assign word_end  = word_q == ake256_pkg::WordIdxW'(ake256_pkg::KeyWords - 1);
  assign pass_last = pass_q == ake256_pkg::PassW'(ake256_pkg::Rounds - 1);
  assign key_last  = key_q == ake256_pkg::KeyIdxW'(ake256_pkg::NumKeys - 1);

  always_comb begin
    ctl_o          = '0;
    ctl_o.idle     = state_q == ake256_pkg::ST_IDLE;
    ctl_o.load     = ctl_o.idle && in_valid_i;
    ctl_o.mix      = state_q == ake256_pkg::ST_MIX;
    ctl_o.step     = state_q == ake256_pkg::ST_DIFF;
    ctl_o.pass_end = ctl_o.step && word_end;
    ctl_o.emit     = (state_q == ake256_pkg::ST_EMIT) && slot_free_i;
    ctl_o.last     = key_last;
    ctl_o.word_idx = word_q;
    ctl_o.key_idx  = key_q;
  end

  always_comb begin
    state_d = state_q;
    word_d  = word_q;
    pass_d  = pass_q;
    key_d   = key_q;
    unique case (state_q)
      ake256_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          key_d   = '0;
          state_d = ake256_pkg::ST_MIX;
        end
      end
      ake256_pkg::ST_MIX: begin
        word_d  = '0;
        pass_d  = '0;
        state_d = ake256_pkg::ST_DIFF;
      end
      ake256_pkg::ST_DIFF: begin
        word_d = word_q + 1'b1;
        if (word_end) begin
          pass_d = pass_q + 1'b1;
          if (pass_last) state_d = ake256_pkg::ST_EMIT;
        end
      end
      ake256_pkg::ST_EMIT: begin
        if (slot_free_i) begin
          if (key_last) begin
            state_d = ake256_pkg::ST_IDLE;
          end else begin
            key_d   = key_q + 1'b1;
            state_d = ake256_pkg::ST_MIX;
          end
        end
      end
      default: state_d = ake256_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ake256_pkg::ST_IDLE;
      word_q  <= '0;
      pass_q  <= '0;
      key_q   <= '0;
    end else begin
      state_q <= state_d;
      word_q  <= word_d;
      pass_q  <= pass_d;
      key_q   <= key_d;
    end
  end

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.load |=> (state_q == ake256_pkg::ST_MIX) && (key_q == '0))
    else $error("key load did not start at round key zero");

  a_last_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_o.emit && key_last) |=> state_q == ake256_pkg::ST_IDLE)
    else $error("last round key did not return to idle");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ake256_pkg::ST_EMIT && !slot_free_i) |=>
      (state_q == ake256_pkg::ST_EMIT) && $stable(key_q))
    else $error("emission moved on while output stalled");

  a_mix_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.mix |=> (word_q == '0) && (pass_q == '0))
    else $error("diffusion started unaligned");

endmodule

// ===== rtl/arx_key_expansion_256_core.sv =====
// ARX key expansion, 256-bit key: top level with working registers and output word register.
// Depends on ake256_pkg, ake256_if, ake256_word_unit and ake256_ctrl.
//
// key_i takes one 256-bit key as four 64-bit words (byte 0 in bits 7:0 of the first).
// rk_o delivers Rounds/2 round keys per key, each tagged with its index; the last one
// carries final_round_key. Both channels move a word when valid and ready are high.
// key_i.ready is high only while the block is idle.
// Per round key: byte mixing, Rounds diffusion passes over the eight working words (one
// working word updated per cycle by the shared add-rotate-add unit), then emission.
// A round key waits in the output register while rk_o.ready is low; the sequencer
// holds the next finished round key until the register frees. After the last round
// key is loaded the block is idle again and takes a new key while it waits.
// Reset clears the sequencer and the output valid; no clearing pass is needed.
module arx_key_expansion_256_core (
  input  logic clk_i,
  input  logic rst_ni,
  ake256_key_if.sink  key_i,
  ake256_rk_if.source rk_o
);

  localparam int unsigned HalfBytes = ake256_pkg::KeyWords * 2;

  ake256_pkg::ctl_t                           ctl;
  logic [ake256_pkg::KeyWords*32-1:0]         orig_q;
  logic [ake256_pkg::KeyWords-1:0][31:0]      work_q, work_d;
  logic [ake256_pkg::KeyWords*32-1:0]         key_vec, work_flat, mixed;
  logic [31:0]                                rc_q, new_word;
  logic                                       out_valid_q, slot_free;
  logic [ake256_pkg::KeyIdxW-1:0]             out_idx_q;
  logic [ake256_pkg::KeyWords*32-1:0]         out_key_q;
  logic                                       out_last_q;

  function automatic logic [7:0] nswap(input logic [7:0] b);
    return {b[3:0], b[7:4]};
  endfunction

  assign key_vec   = {key_i.key_bytes_24_31, key_i.key_bytes_16_23,
                      key_i.key_bytes_8_15, key_i.key_bytes_0_7};
  assign work_flat = work_q;
  assign slot_free = !out_valid_q || rk_o.ready;
  assign key_i.ready = ctl.idle;

  ake256_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (key_i.valid),
    .slot_free_i (slot_free),
    .ctl_o       (ctl)
  );

  ake256_word_unit u_word (
    .a_i   (work_q[0]),
    .b_i   (work_q[1]),
    .c_i   (work_q[2]),
    .d_i   (work_q[3]),
    .rc_i  (rc_q),
    .idx_i (ctl.word_idx),
    .y_o   (new_word)
  );

  always_comb begin
    mixed = work_flat;
    for (int i = 0; i < HalfBytes; i++) begin
      mixed[8*i +: 8] = work_flat[8*i +: 8] + orig_q[8*i +: 8]
                        + nswap(orig_q[8*(i+HalfBytes) +: 8]);
      mixed[8*(i+HalfBytes) +: 8] = work_flat[8*(i+HalfBytes) +: 8]
                        + orig_q[8*(i+HalfBytes) +: 8] + nswap(orig_q[8*i +: 8]);
    end
  end

  // words rotate down one place per update, so the unit always sees fixed taps
  always_comb begin
    work_d = work_q;
    if (ctl.load) begin
      work_d = key_vec ^ ake256_pkg::XorConst;
    end else if (ctl.mix) begin
      work_d = mixed;
    end else if (ctl.step) begin
      work_d = {new_word, work_q[ake256_pkg::KeyWords-1:1]};
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    if (ctl.load) begin
      orig_q <= key_vec;
      rc_q   <= ake256_pkg::Golden;
    end else if (ctl.pass_end) begin
      rc_q   <= rc_q + ake256_pkg::Golden;
    end
    if (ctl.emit) begin
      out_idx_q  <= ctl.key_idx;
      out_key_q  <= work_flat;
      out_last_q <= ctl.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.emit) begin
      out_valid_q <= 1'b1;
    end else if (rk_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign rk_o.valid             = out_valid_q;
  assign rk_o.round_number      = out_idx_q;
  assign rk_o.round_bytes_0_7   = out_key_q[63:0];
  assign rk_o.round_bytes_8_15  = out_key_q[127:64];
  assign rk_o.round_bytes_16_23 = out_key_q[191:128];
  assign rk_o.round_bytes_24_31 = out_key_q[255:192];
  assign rk_o.final_round_key   = out_last_q;

endmodule

// ===== test/ake256_round_key_checker.sv =====
// ake256_round_key_checker: watches the key and round-key channels, predicts every round key
// and compares each received word field by field. Depends on ake256_pkg and ake256_if.
module ake256_round_key_checker (
  input  logic  clk_i,
  input  logic  rst_ni,
  ake256_key_if key_i,
  ake256_rk_if  rk_i,
  output int    mismatch_count_o,
  output int    pending_o,
  output int    keys_seen_o,
  output int    round_keys_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxPrinted = 40;
  localparam logic [31:0] GoldenRatio = 32'h9E3779B9;
  localparam logic [31:0] WhitenWords [8] = '{
    32'h38183a08, 32'h7bd0dfca, 32'h25e9e4d5, 32'hcf4c5d88,
    32'h98317698, 32'h2ef6ef14, 32'h47c6abd9, 32'h644c7ad7
  };
  localparam int RotLeft [8] = '{7, 11, 21, 8, 2, 13, 12, 17};

  typedef struct packed {
    logic [4:0]   idx;
    logic [255:0] bytes;
    logic         last;
  } round_key_t;

  round_key_t expected_q[$];
  round_key_t want;
  int mismatches = 0;
  int pending_count = 0;
  int keys_seen = 0;
  int round_keys_seen = 0;

  assign mismatch_count_o  = mismatches;
  assign pending_o         = pending_count;
  assign keys_seen_o       = keys_seen;
  assign round_keys_seen_o = round_keys_seen;

  function automatic logic [7:0] swap_nibbles(input logic [7:0] b);
    return {b[3:0], b[7:4]};
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // Queues the NumKeys round keys that one input key expands into.
  function automatic void expand_key(input logic [255:0] key);
    logic [255:0] work;
    logic [31:0]  w [8];
    logic [31:0]  rc;
    logic [31:0]  s;
    round_key_t   rk;
    for (int i = 0; i < 8; i++) work[32*i +: 32] = key[32*i +: 32] ^ WhitenWords[i];
    for (int k = 0; k < ake256_pkg::NumKeys; k++) begin
      for (int i = 0; i < 16; i++) begin
        work[8*i +: 8] = work[8*i +: 8] + key[8*i +: 8] + swap_nibbles(key[8*(i+16) +: 8]);
        work[8*(i+16) +: 8] = work[8*(i+16) +: 8] + key[8*(i+16) +: 8]
                              + swap_nibbles(key[8*i +: 8]);
      end
      for (int i = 0; i < 8; i++) w[i] = work[32*i +: 32];
      for (int r = 0; r < ake256_pkg::Rounds; r++) begin
        rc = GoldenRatio * 32'(r + 1 + k * ake256_pkg::Rounds);
        for (int i = 0; i < 8; i++) begin
          s = w[(i+1)%8] + w[(i+2)%8];
          w[i] = w[i] + rotl32(s, RotLeft[i]) + w[(i+3)%8] + rc;
        end
      end
      for (int i = 0; i < 8; i++) work[32*i +: 32] = w[i];
      rk.idx   = 5'(k);
      rk.bytes = work;
      rk.last  = (k == ake256_pkg::NumKeys - 1);
      expected_q.push_back(rk);
    end
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp_v);
    if (mismatches < MaxPrinted)
      $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, exp_v);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (key_i.valid && key_i.ready) begin
        expand_key({key_i.key_bytes_24_31, key_i.key_bytes_16_23,
                    key_i.key_bytes_8_15, key_i.key_bytes_0_7});
        keys_seen++;
      end
      if (rk_i.valid && rk_i.ready) begin
        round_keys_seen++;
        if (expected_q.size() == 0) begin
          report("round key word with none due", 64'(rk_i.round_number), '0);
        end else begin
          want = expected_q.pop_front();
          if (rk_i.round_number !== want.idx)
            report("round_number", 64'(rk_i.round_number), 64'(want.idx));
          if (rk_i.round_bytes_0_7 !== want.bytes[63:0])
            report("round_bytes_0_7", rk_i.round_bytes_0_7, want.bytes[63:0]);
          if (rk_i.round_bytes_8_15 !== want.bytes[127:64])
            report("round_bytes_8_15", rk_i.round_bytes_8_15, want.bytes[127:64]);
          if (rk_i.round_bytes_16_23 !== want.bytes[191:128])
            report("round_bytes_16_23", rk_i.round_bytes_16_23, want.bytes[191:128]);
          if (rk_i.round_bytes_24_31 !== want.bytes[255:192])
            report("round_bytes_24_31", rk_i.round_bytes_24_31, want.bytes[255:192]);
          if (rk_i.final_round_key !== want.last)
            report("final_round_key", 64'(rk_i.final_round_key), 64'(want.last));
        end
      end
      pending_count = expected_q.size();
    end
  end

endmodule

// ===== test/tb_top.sv =====
// tb_top: clock, reset and stimulus for arx_key_expansion_256_core, with random idling on
// both channels. Depends on ake256_pkg, ake256_if, the core and ake256_round_key_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit  = 1_000_000;
  localparam int RandomKeys  = 155;
  localparam int DrainCycles = 300;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  bit   sink_stalls = 1'b0;
  bit   source_gaps = 1'b0;
  int   cycle_count = 0;
  int   mismatches;
  int   pending_keys;
  int   keys_seen;
  int   round_keys_seen;

  ake256_key_if key_if ();
  ake256_rk_if  rk_if ();

  arx_key_expansion_256_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .key_i  (key_if),
    .rk_o   (rk_if)
  );

  ake256_round_key_checker rk_check (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .key_i             (key_if),
    .rk_i              (rk_if),
    .mismatch_count_o  (mismatches),
    .pending_o         (pending_keys),
    .keys_seen_o       (keys_seen),
    .round_keys_seen_o (round_keys_seen)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [255:0] random_key();
    logic [255:0] k;
    int style;
    for (int i = 0; i < 8; i++) k[32*i +: 32] = $urandom();
    style = $urandom_range(0, 9);
    if (style < 2) begin
      for (int i = 0; i < 8; i++) k[32*i +: 32] &= $urandom() & $urandom();
    end else if (style < 4) begin
      for (int i = 0; i < 32; i++) begin
        case ($urandom_range(0, 5))
          0: k[8*i +: 8] = 8'h00;
          1: k[8*i +: 8] = 8'hff;
          2: k[8*i +: 8] = 8'h0f;
          3: k[8*i +: 8] = 8'hf0;
          4: k[8*i +: 8] = 8'h80;
          default: k[8*i +: 8] = 8'h7f;
        endcase
      end
    end
    return k;
  endfunction

  task automatic send_key(input logic [255:0] key);
    int gap;
    gap = source_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk_i) key_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    key_if.valid <= 1'b1;
    {key_if.key_bytes_24_31, key_if.key_bytes_16_23,
     key_if.key_bytes_8_15, key_if.key_bytes_0_7} <= key;
    do @(posedge clk_i); while (!key_if.ready);
  endtask

  task automatic wait_all_round_keys();
    @(negedge clk_i) key_if.valid <= 1'b0;
    while (pending_keys != 0) @(negedge clk_i);
  endtask

  initial begin
    int hold;
    rk_if.ready = 1'b0;
    forever begin
      hold = pick_gap();
      if (sink_stalls && hold > 0) begin
        @(negedge clk_i) rk_if.ready <= 1'b0;
        repeat (hold - 1) @(negedge clk_i);
      end
      @(negedge clk_i) rk_if.ready <= 1'b1;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d round keys outstanding", cycle_count, pending_keys);
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [255:0] whiten;
    logic [255:0] directed [$];
    key_if.valid           = 1'b0;
    key_if.key_bytes_0_7   = '0;
    key_if.key_bytes_8_15  = '0;
    key_if.key_bytes_16_23 = '0;
    key_if.key_bytes_24_31 = '0;
    whiten = ake256_pkg::XorConst;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // extremes, nibble patterns and keys that cancel or invert the whitening
    directed = '{'0, '1,
                 {192'h0, 64'hffff_ffff_ffff_ffff}, {128'h0, 64'hffff_ffff_ffff_ffff, 64'h0},
                 {64'h0, 64'hffff_ffff_ffff_ffff, 128'h0}, {64'hffff_ffff_ffff_ffff, 192'h0},
                 {32{8'haa}}, {32{8'h55}}, {32{8'h0f}}, {32{8'hf0}},
                 {32{8'h80}}, {32{8'h7f}}, whiten, ~whiten,
                 {{16{8'hff}}, {16{8'h00}}}};
    foreach (directed[i]) send_key(directed[i]);
    wait_all_round_keys();

    sink_stalls = 1'b1;
    source_gaps = 1'b1;
    for (int i = 0; i < 60; i++) send_key(random_key());
    sink_stalls = 1'b0;
    for (int i = 0; i < 30; i++) send_key(random_key());
    wait_all_round_keys();
    sink_stalls = 1'b1;
    for (int i = 90; i < RandomKeys; i++) send_key(random_key());

    wait_all_round_keys();
    repeat (DrainCycles) @(posedge clk_i);
    $display("summary: %0d keys expanded (%0d directed), %0d round keys checked in %0d cycles",
             keys_seen, directed.size(), round_keys_seen, cycle_count);
    $display("summary: output stalls and input gaps mixed with stall-free stretches");
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ake256_pkg.sv
rtl/ake256_if.sv
rtl/ake256_word_unit.sv
rtl/ake256_ctrl.sv
rtl/arx_key_expansion_256_core.sv
test/ake256_round_key_checker.sv
test/tb_top.sv
